// File: rtl/u8l2_pkg.sv
package u8l2_pkg;

    // payload of one source beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    // payload of one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_beat_t;

    // up to two result beats written into the output queue at once
    typedef struct packed {
        logic [1:0] cnt;
        out_beat_t  b0;
        out_beat_t  b1;
    } push_t;

    // outcome of one pass over the utf-8 window
    typedef struct packed {
        logic [1:0]      cnt;
        logic [7:0]      e0;
        logic [7:0]      e1;
        logic [1:0]      rem_n;
        logic [2:0][7:0] rem;
    } parse_t;

    localparam int MapCount = 10;

    localparam logic [7:0] LEAD2_MASK = 8'hc0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] LEAD3_MASK = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf0;
    localparam logic [7:0] LEAD4_CHK  = 8'hf8;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    // latin-2 code and its two utf-8 bytes
    localparam logic [7:0] MAP_L2 [MapCount] = '{
        8'he8, 8'hc8, 8'he6, 8'hc6, 8'hf0, 8'hd0, 8'hb9, 8'ha9, 8'hbe, 8'hae
    };
    localparam logic [7:0] MAP_U0 [MapCount] = '{
        8'hc4, 8'hc4, 8'hc4, 8'hc4, 8'hc4, 8'hc4, 8'hc5, 8'hc5, 8'hc5, 8'hc5
    };
    localparam logic [7:0] MAP_U1 [MapCount] = '{
        8'h8d, 8'h8c, 8'h87, 8'h86, 8'h91, 8'h90, 8'ha1, 8'ha0, 8'hbe, 8'hbd
    };

    // sequence length implied by a lead byte, lax check
    function automatic logic [2:0] seq_need(input logic [7:0] c);
        logic [2:0] r;
        if (c < CONT_MARK)
            r = 3'd1;
        else if ((c & LEAD3_MASK) == LEAD3_MASK)
            r = ((c & LEAD4_MASK) == LEAD4_MASK) ? 3'd4 : 3'd3;
        else
            r = 3'd2;
        return r;
    endfunction

    // utf-8 pair to latin-2, hit flag in bit 8
    function automatic logic [8:0] utf_to_l2(input logic [7:0] u0, input logic [7:0] u1);
        logic [8:0] r;
        r = '0;
        for (int k = 0; k < MapCount; k++)
        begin
            if (MAP_U0[k] == u0 && MAP_U1[k] == u1)
                r = {1'b1, MAP_L2[k]};
        end
        return r;
    endfunction

    // latin-2 to utf-8 pair, hit flag in bit 16
    function automatic logic [16:0] l2_to_utf(input logic [7:0] b);
        logic [16:0] r;
        r = '0;
        for (int k = 0; k < MapCount; k++)
        begin
            if (MAP_L2[k] == b)
                r = {1'b1, MAP_U0[k], MAP_U1[k]};
        end
        return r;
    endfunction

    // one pass over pending bytes plus the new byte, at most four steps
    function automatic parse_t utf_parse(input logic [3:0][7:0] win, input logic [2:0] nin,
                                         input logic eot);
        parse_t          r;
        logic [3:0][7:0] w;
        logic [2:0]      n;
        logic [2:0]      need;
        logic [2:0]      drop;
        logic [7:0]      c;
        logic [8:0]      hit;
        logic            bad;
        logic            done;
        logic            emit;
        logic [7:0]      eb;
        r    = '0;
        w    = win;
        n    = nin;
        done = 1'b0;
        for (int it = 0; it < 4; it++)
        begin
            if (!done && n != 3'd0)
            begin
                c    = w[0];
                need = seq_need(c);
                bad  = 1'b0;
                drop = 3'd0;
                emit = 1'b0;
                eb   = c;
                hit  = utf_to_l2(w[0], w[1]);
                if (need == 3'd1)
                begin
                    emit = (c < DIGIT_LO) || (c > DIGIT_HI);
                    drop = 3'd1;
                end
                else
                begin
                    for (int i = 1; i < 4; i++)
                    begin
                        if (3'(i) < need && 3'(i) < n)
                        begin
                            if ((w[i] & LEAD2_MASK) != CONT_MARK)
                                bad = 1'b1;
                            if (i == 3 && (c & LEAD4_CHK) != LEAD4_MASK)
                                bad = 1'b1;
                        end
                    end
                    if (bad)
                        drop = 3'd1;
                    else if (n < need)
                    begin
                        if (eot)
                            drop = 3'd1;
                        else
                            done = 1'b1;
                    end
                    else
                    begin
                        if (need == 3'd2 && hit[8])
                        begin
                            emit = 1'b1;
                            eb   = hit[7:0];
                        end
                        drop = need;
                    end
                end
                // two result beats at most, later ones are lost
                if (emit)
                begin
                    if (r.cnt == 2'd0)
                    begin
                        r.e0  = eb;
                        r.cnt = 2'd1;
                    end
                    else if (r.cnt == 2'd1)
                    begin
                        r.e1  = eb;
                        r.cnt = 2'd2;
                    end
                end
                w = w >> {drop, 3'b000};
                n = n - drop;
            end
        end
        r.rem_n = n[1:0];
        r.rem   = w[2:0];
        return r;
    endfunction

endpackage

// File: rtl/u8l2_decode.sv
module u8l2_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               direction,
    input  logic               cfg_wr,
    input  logic               src_valid,
    output logic               src_stall,
    input  u8l2_pkg::in_beat_t src_beat,
    input  logic               room,
    output logic               push_en,
    output u8l2_pkg::push_t    push
);
    import u8l2_pkg::*;

    logic            stg_valid_reg;
    logic            stg_valid_next;
    in_beat_t        stg_beat_reg;
    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      pend_cnt_reg;
    logic [1:0]      pend_cnt_next;
    logic [3:0][7:0] win;
    parse_t          pr;
    logic [16:0]     l2hit;
    logic            advance;
    logic            take;

    // stage handshake: hold the beat until the queue has room for two
    assign advance   = stg_valid_reg && room;
    assign src_stall = stg_valid_reg && !room;
    assign take      = src_valid && !src_stall;
    assign push_en   = advance;

    // window of pending bytes with the new byte appended
    always_comb
    begin
        win                = {8'h00, pend_reg};
        win[pend_cnt_reg]  = stg_beat_reg.in_byte;
    end

    assign pr    = utf_parse(win, {1'b0, pend_cnt_reg} + 3'd1, stg_beat_reg.end_of_text);
    assign l2hit = l2_to_utf(stg_beat_reg.in_byte);

    // result beats for this item
    always_comb
    begin
        push = '0;
        if (direction)
        begin
            if (l2hit[16])
            begin
                push.cnt = 2'd2;
                push.b0  = '{out_byte: l2hit[15:8], last_of_run: 1'b0};
                push.b1  = '{out_byte: l2hit[7:0], last_of_run: 1'b1};
            end
            else
            begin
                push.cnt = 2'd1;
                push.b0  = '{out_byte: stg_beat_reg.in_byte, last_of_run: 1'b1};
            end
        end
        else
        begin
            push.cnt = pr.cnt;
            push.b0  = '{out_byte: pr.e0, last_of_run: (pr.cnt == 2'd1)};
            push.b1  = '{out_byte: pr.e1, last_of_run: 1'b1};
        end
    end

    // pending sequence update
    always_comb
    begin
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        if (cfg_wr)
            pend_cnt_next = 2'd0;
        else if (advance && !direction)
        begin
            pend_next     = pr.rem;
            pend_cnt_next = pr.rem_n;
        end
    end

    assign stg_valid_next = take ? 1'b1 : (advance ? 1'b0 : stg_valid_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            pend_cnt_reg  <= 2'd0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
            stg_beat_reg <= src_beat;
        pend_reg <= pend_next;
    end

endmodule

// File: rtl/u8l2_out_queue.sv
module u8l2_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  u8l2_pkg::push_t     push,
    output logic                room,
    output logic                dst_valid,
    input  logic                dst_stall,
    output u8l2_pkg::out_beat_t dst_beat
);
    import u8l2_pkg::*;

    out_beat_t  ent_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [1:0] n_push;
    logic       pop;

    assign n_push    = push_en ? push.cnt : 2'd0;
    assign pop       = dst_valid && !dst_stall;
    assign room      = cnt_reg <= 3'd2;
    assign dst_valid = cnt_reg != 3'd0;
    assign dst_beat  = ent_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + n_push;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign cnt_next    = cnt_reg + {1'b0, n_push} - {2'b00, pop};

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry write, two beats land in consecutive slots
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            ent_reg[wr_ptr_reg] <= push.b0;
        if (n_push == 2'd2)
            ent_reg[wr_ptr_reg + 2'd1] <= push.b1;
    end

endmodule

// File: rtl/utf8_latin2_transcoder_core.sv
// path: a source beat is registered in the stage register and, once the queue has
// room, written into a result queue entry, from which its first result is presented
// throughput: one source beat per cycle while each yields at most one result and
// the receiver does not stall; the queue drains one beat per cycle when not stalled
// the path and rate are set by the stage register and the four-entry result queue
// reset: direction returns to utf-8 to latin-2, pending sequence and queue empty
module utf8_latin2_transcoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                src_valid,
    output logic                src_stall,
    input  u8l2_pkg::in_beat_t  src_beat,
    output logic                dst_valid,
    input  logic                dst_stall,
    output u8l2_pkg::out_beat_t dst_beat
);
    import u8l2_pkg::*;

    localparam logic REG_DIRECTION = 1'b0;

    logic    dir_reg;
    logic    dir_next;
    logic    cfg_wr;
    logic    room;
    logic    push_en;
    push_t   push;

    // register port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
    assign dir_next = cfg_wr ? pwdata[0] : dir_reg;
    assign prdata   = (paddr[2] == REG_DIRECTION) ? {31'd0, dir_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= 1'b0;
        else
            dir_reg <= dir_next;
    end

    u8l2_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (dir_reg),
        .cfg_wr    (cfg_wr),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .room      (room),
        .push_en   (push_en),
        .push      (push)
    );

    u8l2_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push      (push),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_beat  (dst_beat)
    );

endmodule

// File: rtl/u8l2_checker.sv
module u8l2_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [2:0]          paddr,
    input logic [31:0]         pwdata,
    input logic [31:0]         prdata,
    input logic                pready,
    input logic                src_stall,
    input logic                dst_valid,
    input logic                dst_stall,
    input u8l2_pkg::out_beat_t dst_beat
);
    import u8l2_pkg::*;

    // a stalled result beat holds
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_beat))
        else $error("result beat changed while stalled");

    // the source side only backs up behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid)
        else $error("source stalled with no result waiting");

    // the first byte of an expansion is always followed by its partner
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_stall && !dst_beat.last_of_run |=> dst_valid)
        else $error("first byte of a pair without its partner");

    // direction reads back what was written
    a_dir_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1
        (psel && !pwrite && !paddr[2]) |-> prdata == {31'd0, $past(pwdata[0])})
        else $error("direction readback mismatch");

endmodule

bind utf8_latin2_transcoder_core u8l2_checker u_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import u8l2_pkg::*;

    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic       DIR_U8_TO_L2  = 1'b0;
    localparam logic       DIR_L2_TO_U8  = 1'b1;
    localparam int         CHAR_COUNT    = 10;
    localparam logic [1:0] CONT_TAG      = 2'b10;
    localparam logic [4:0] LEAD4_TAG     = 5'b11110;
    localparam logic [7:0] DIGIT_ZERO    = 8'h30;
    localparam logic [7:0] DIGIT_NINE    = 8'h39;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         IDLE_LIMIT    = 2000;

    typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        src_valid;
    logic        src_stall;
    in_beat_t    src_beat;
    logic        dst_valid;
    logic        dst_stall;
    out_beat_t   dst_beat;

    // predicted transcoder state
    logic            model_dir;
    logic [2:0][7:0] seq_buf;
    int              seq_cnt;
    out_beat_t       expected_text [$];

    int        mismatch_count = 0;
    int        beats_sent     = 0;
    int        burst_left     = 0;
    int        tx_gap_max     = 0;
    rx_mode_t  rx_mode        = RX_FREE;
    logic      hold_req       = 1'b0;
    int        idle_cycles    = 0;
    out_beat_t head_beat;

    utf8_latin2_transcoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_beat  (dst_beat)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // {latin-2 code, utf-8 lead, utf-8 trail} of each supported letter
    function automatic logic [23:0] map_entry(input int k);
        case (k)
            0: return 24'he8c48d;
            1: return 24'hc8c48c;
            2: return 24'he6c487;
            3: return 24'hc6c486;
            4: return 24'hf0c491;
            5: return 24'hd0c490;
            6: return 24'hb9c5a1;
            7: return 24'ha9c5a0;
            8: return 24'hbec5be;
            default: return 24'haec5bd;
        endcase
    endfunction

    // sequence length claimed by a lead byte
    function automatic int lead_len(input logic [7:0] c);
        if (c[7] == 1'b0)
            return 1;
        if (c[7:5] != 3'b111)
            return 2;
        if (c[4] == 1'b0)
            return 3;
        return 4;
    endfunction

    // expected output beats for one accepted source beat
    task automatic transcode(input in_beat_t beat);
        logic [3:0][7:0] w;
        logic [7:0]      lead;
        logic [7:0]      res [2];
        logic [23:0]     ent;
        logic            bad;
        out_beat_t       ob;
        int              n;
        int              need;
        int              k;
        int              cnt;
        cnt = 0;
        if (model_dir == DIR_L2_TO_U8)
        begin
            res[0] = beat.in_byte;
            cnt    = 1;
            for (k = 0; k < CHAR_COUNT; k++)
            begin
                ent = map_entry(k);
                if (ent[23:16] == beat.in_byte)
                begin
                    res[0] = ent[15:8];
                    res[1] = ent[7:0];
                    cnt    = 2;
                end
            end
        end
        else
        begin
            w          = '0;
            w[2:0]     = seq_buf;
            w[seq_cnt] = beat.in_byte;
            n          = seq_cnt + 1;
            while (n > 0)
            begin
                lead = w[0];
                need = lead_len(lead);
                bad  = 1'b0;
                if (need == 1)
                begin
                    // ascii passes except digits
                    if ((lead < DIGIT_ZERO || lead > DIGIT_NINE) && cnt < 2)
                    begin
                        res[cnt] = lead;
                        cnt++;
                    end
                    w = w >> 8;
                    n--;
                end
                else
                begin
                    for (k = 1; k < need && k < n; k++)
                    begin
                        if (w[k][7:6] != CONT_TAG)
                            bad = 1'b1;
                        if (k == 3 && lead[7:3] != LEAD4_TAG)
                            bad = 1'b1;
                    end
                    // drop the lead on a broken or abandoned sequence
                    if (bad || (n < need && beat.end_of_text))
                    begin
                        w = w >> 8;
                        n--;
                    end
                    else if (n < need)
                        break;
                    else
                    begin
                        if (need == 2)
                        begin
                            for (k = 0; k < CHAR_COUNT; k++)
                            begin
                                ent = map_entry(k);
                                if (ent[15:8] == w[0] && ent[7:0] == w[1] && cnt < 2)
                                begin
                                    res[cnt] = ent[23:16];
                                    cnt++;
                                end
                            end
                        end
                        w = w >> (8 * need);
                        n = n - need;
                    end
                end
            end
            seq_buf = w[2:0];
            seq_cnt = n;
        end
        for (k = 0; k < cnt; k++)
        begin
            ob.out_byte    = res[k];
            ob.last_of_run = (k == cnt - 1);
            expected_text = {expected_text, ob};
        end
    endtask

    // apb write of the direction register, pending sequence is flushed
    task automatic set_direction(input logic dir);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DIRECTION;
        pwdata  <= {31'b0, dir};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_dir = dir;
        seq_buf   = '0;
        seq_cnt   = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one source beat, with bursts and random gaps
    task automatic send_beat(input logic [7:0] b, input logic eot);
        in_beat_t beat;
        int       gap;
        beat.in_byte     = b;
        beat.end_of_text = eot;
        if (tx_gap_max > 0 && burst_left <= 0)
        begin
            burst_left = $urandom_range(16, 1);
            gap        = $urandom_range(tx_gap_max, 0);
            if (gap > 0)
            begin
                @(negedge clk);
                src_valid <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        src_valid <= 1'b1;
        src_beat  <= beat;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        beats_sent++;
        transcode(beat);
    endtask

    // stop offering and wait until every expected beat is out
    task automatic settle_block();
        @(negedge clk);
        src_valid <= 1'b0;
        burst_left = 0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // one utf-8 character: mostly well formed, some broken, some noise
    task automatic send_utf8_char();
        logic [7:0]  seq [4];
        logic [23:0] ent;
        int          pick;
        int          len;
        int          k;
        pick = $urandom_range(99, 0);
        len  = 1;
        if (pick < 30)
            seq[0] = 8'($urandom_range(127, 0));
        else if (pick < 50)
        begin
            ent    = map_entry($urandom_range(CHAR_COUNT - 1, 0));
            seq[0] = ent[15:8];
            seq[1] = ent[7:0];
            len    = 2;
        end
        else if (pick < 85)
        begin
            len = $urandom_range(4, 2);
            case (len)
                2: seq[0] = {3'b110, 5'($urandom)};
                3: seq[0] = {4'b1110, 4'($urandom)};
                default: seq[0] = {LEAD4_TAG, 3'($urandom)};
            endcase
            for (k = 1; k < len; k++)
                seq[k] = {CONT_TAG, 6'($urandom)};
            // truncate, corrupt a trailer, or use an oversized lead
            if (pick >= 72)
            begin
                k = $urandom_range(len - 1, 1);
                case ($urandom_range(2, 0))
                    0: len = k;
                    1: seq[k] = 8'($urandom);
                    default: seq[0] = {5'b11111, 3'($urandom)};
                endcase
            end
        end
        else
            seq[0] = 8'($urandom);
        for (k = 0; k < len; k++)
            send_beat(seq[k], $urandom_range(99, 0) < 3);
    endtask

    task automatic send_utf8_text(input int count);
        int start;
        start = beats_sent;
        while (beats_sent - start < count)
            send_utf8_char();
    endtask

    task automatic send_latin2_text(input int count, input int map_pct);
        logic [23:0] ent;
        logic [7:0]  b;
        repeat (count)
        begin
            ent = map_entry($urandom_range(CHAR_COUNT - 1, 0));
            b   = ($urandom_range(99, 0) < map_pct) ? ent[23:16] : 8'($urandom);
            send_beat(b, $urandom_range(99, 0) < 5);
        end
    endtask

    task automatic test_utf8_directed();
        set_direction(DIR_U8_TO_L2);
        tx_gap_max = 3;
        rx_mode    = RX_BURSTY;
        // ascii extremes and digit boundaries
        send_beat(8'h41, 1'b0); send_beat(8'h30, 1'b0); send_beat(8'h39, 1'b0);
        send_beat(8'h2f, 1'b0); send_beat(8'h3a, 1'b0); send_beat(8'h00, 1'b0);
        send_beat(8'h7f, 1'b0);
        // mapped pair, then a well-formed pair with no mapping
        send_beat(8'hc4, 1'b0); send_beat(8'h8d, 1'b0);
        send_beat(8'hc4, 1'b0); send_beat(8'h80, 1'b0);
        // four-byte character, dropped
        send_beat(8'hf0, 1'b0); send_beat(8'h9f, 1'b0);
        send_beat(8'h98, 1'b0); send_beat(8'h80, 1'b0);
        // four-byte lead out of range, trailers re-parsed
        send_beat(8'hf8, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(8'h80, 1'b0); send_beat(8'h80, 1'b0);
        // bad continuation
        send_beat(8'hc4, 1'b0); send_beat(8'h41, 1'b0);
        // partial sequence cut by end of text
        send_beat(8'he2, 1'b0); send_beat(8'h82, 1'b1);
        send_beat(8'hff, 1'b1);
        settle_block();
    endtask

    task automatic test_latin2_directed();
        set_direction(DIR_L2_TO_U8);
        send_beat(8'he8, 1'b0); send_beat(8'hae, 1'b0); send_beat(8'h41, 1'b0);
        send_beat(8'hff, 1'b0); send_beat(8'hc4, 1'b0); send_beat(8'he8, 1'b1);
        send_beat(8'h00, 1'b1);
        settle_block();
    endtask

    task automatic test_utf8_random();
        set_direction(DIR_U8_TO_L2);
        tx_gap_max = 6;
        rx_mode    = RX_RANDOM;
        send_utf8_text(250);
        rx_mode = RX_BURSTY;
        send_utf8_text(200);
        settle_block();
    endtask

    task automatic test_latin2_random();
        set_direction(DIR_L2_TO_U8);
        tx_gap_max = 5;
        rx_mode    = RX_BURSTY;
        send_latin2_text(180, 50);
        rx_mode = RX_RANDOM;
        send_latin2_text(150, 30);
        settle_block();
    endtask

    // receiver holds off while two-beat expansions keep coming
    task automatic test_output_backpressure();
        tx_gap_max = 0;
        rx_mode    = RX_FREE;
        hold_req   = 1'b1;
        send_latin2_text(60, 90);
        settle_block();
    endtask

    task automatic test_full_rate();
        set_direction(DIR_U8_TO_L2);
        tx_gap_max = 0;
        rx_mode    = RX_FREE;
        send_utf8_text(80);
        settle_block();
        set_direction(DIR_L2_TO_U8);
        send_latin2_text(50, 40);
        settle_block();
    endtask

    // receiver stall pattern and long hold-off
    initial
    begin
        int   run;
        logic level;
        dst_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                dst_stall <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM: dst_stall <= ($urandom_range(99, 0) < 35);
                    RX_BURSTY:
                    begin
                        if (run <= 0)
                        begin
                            run   = $urandom_range(12, 1);
                            level = ~level;
                        end
                        run--;
                        dst_stall <= level;
                    end
                    default: dst_stall <= 1'b0;
                endcase
            end
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %02h/%0b",
                         $time, dst_beat.out_byte, dst_beat.last_of_run);
                mismatch_count++;
            end
            else
            begin
                head_beat = expected_text.pop_front();
                if (dst_beat.out_byte !== head_beat.out_byte)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, head_beat.out_byte, dst_beat.out_byte);
                    mismatch_count++;
                end
                if (dst_beat.last_of_run !== head_beat.last_of_run)
                begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, head_beat.last_of_run, dst_beat.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        src_valid = 1'b0;
        src_beat  = '0;
        model_dir = DIR_U8_TO_L2;
        seq_buf   = '0;
        seq_cnt   = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_utf8_directed();
        test_latin2_directed();
        test_utf8_random();
        test_latin2_random();
        test_output_backpressure();
        test_full_rate();

        settle_block();
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
